// ===== hw/rtl/ljf_pkg.sv =====
// shared types, constants and helpers for the shifted 12-6 pair force kernel
// no dependencies; every rtl file refers to it by scoped names
package ljf_pkg;

  localparam int SmulLat   = 5;
  localparam int SqrtSteps = 32;
  localparam int DivSteps  = 57;

  localparam logic [1:0] StInteract   = 2'd0;
  localparam logic [1:0] StBeyond     = 2'd1;
  localparam logic [1:0] StCoincident = 2'd2;

  localparam logic [2:0] CfgSigma    = 3'd0;
  localparam logic [2:0] CfgYZero    = 3'd1;
  localparam logic [2:0] CfgStrength = 3'd2;
  localparam logic [2:0] CfgCutoff   = 3'd3;
  localparam logic [2:0] CfgEShift   = 3'd4;
  localparam logic [2:0] CfgSShift   = 3'd5;
  localparam logic [2:0] CfgInvS0Sq  = 3'd6;

  localparam logic [30:0]        SigmaReset    = 31'd16777216;
  localparam logic [30:0]        YZeroReset    = 31'd16777216;
  localparam logic signed [31:0] StrengthReset = 32'sd16777216;
  localparam logic [30:0]        CutoffReset   = 31'd33554432;
  localparam logic [30:0]        InvS0SqReset  = 31'd16777216;

  localparam logic [5:0] ShQ = 6'd32;
  localparam logic [5:0] ShA = 6'd24;
  localparam logic [5:0] ShS = 6'd16;
  localparam logic [5:0] ShE = 6'd40;
  localparam logic [5:0] ShW = 6'd48;

  localparam logic signed [63:0] SMax  = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] SMin  = 64'sh8000_0000_0000_0000;
  localparam logic signed [63:0] One32 = 64'sh0000_0001_0000_0000;

  typedef struct packed {
    logic signed [31:0] xi;
    logic signed [31:0] yi;
    logic signed [31:0] zi;
    logic signed [31:0] xj;
    logic signed [31:0] yj;
    logic signed [31:0] zj;
    logic [30:0]        pair_weight;
  } ljf_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [63:0] pair_energy;
    logic signed [63:0] force_x;
    logic signed [63:0] force_y;
    logic signed [63:0] force_z;
  } ljf_out_t;

  typedef struct packed {
    logic               valid;
    logic [1:0]         status;
    logic               far;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [32:0] dz;
    logic [31:0]        mx;
    logic [31:0]        my;
    logic [31:0]        mz;
    logic [63:0]        sx;
    logic [63:0]        sy;
    logic [63:0]        sz;
    logic [30:0]        pw;
    logic signed [63:0] w;
    logic [65:0]        d2;
    logic [31:0]        r;
    logic signed [63:0] q;
    logic signed [63:0] p;
    logic signed [63:0] p2;
    logic signed [63:0] p4;
    logic signed [63:0] p6;
    logic signed [63:0] q2;
    logic signed [63:0] q4;
    logic signed [63:0] q6;
    logic signed [63:0] q7;
    logic signed [63:0] ce;
    logic signed [63:0] cd;
    logic signed [63:0] rmr;
    logic signed [63:0] t1;
    logic signed [63:0] t2;
    logic signed [63:0] st;
    logic signed [63:0] e;
    logic signed [63:0] dv;
    logic signed [63:0] en;
    logic signed [63:0] f;
    logic signed [63:0] g;
    logic signed [63:0] fx;
    logic signed [63:0] fy;
    logic signed [63:0] fz;
  } ljf_rec_t;

  function automatic logic signed [63:0] ssub(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    logic signed [64:0] t;
    t = {a[63], a} - {b[63], b};
    if (t[64] != t[63]) begin
      return t[64] ? SMin : SMax;
    end
    return t[63:0];
  endfunction

  function automatic logic [31:0] mag33(input logic signed [32:0] x);
    logic [32:0] t;
    t = x[32] ? 33'(-x) : 33'(x);
    return t[31:0];
  endfunction

  // record with its valid bit dropped while reset is high
  function automatic ljf_rec_t gate_valid(input ljf_rec_t r, input logic rst);
    ljf_rec_t t;
    t       = r;
    t.valid = r.valid & ~rst;
    return t;
  endfunction

endpackage

// ===== hw/rtl/ljf_smul.sv =====
// five stage saturating fixed point multiplier: |a|*|b| from 32x32 partial products,
// truncating shift and signed saturation; uses ljf_pkg
module ljf_smul (
  input  logic               clk,
  input  logic signed [63:0] a,
  input  logic signed [63:0] b,
  input  logic [5:0]         shift,
  output logic signed [63:0] y
);

  logic         neg1, neg2, neg3, neg4;
  logic [63:0]  am, bm;
  logic [63:0]  ll, lh, hl, hh;
  logic [64:0]  mid;
  logic [63:0]  ll3, hh3;
  logic [127:0] prod;
  logic [127:0] sh;
  logic         big;

  always_ff @(posedge clk) begin
    neg1 <= a[63] ^ b[63];
    am   <= a[63] ? 64'(-a) : 64'(a);
    bm   <= b[63] ? 64'(-b) : 64'(b);
    neg2 <= neg1;
    ll   <= {32'b0, am[31:0]} * {32'b0, bm[31:0]};
    lh   <= {32'b0, am[31:0]} * {32'b0, bm[63:32]};
    hl   <= {32'b0, am[63:32]} * {32'b0, bm[31:0]};
    hh   <= {32'b0, am[63:32]} * {32'b0, bm[63:32]};
    neg3 <= neg2;
    mid  <= {1'b0, lh} + {1'b0, hl};
    ll3  <= ll;
    hh3  <= hh;
    neg4 <= neg3;
    prod <= {hh3, ll3} + (128'(mid) << 32);
  end

  always_comb begin
    sh  = prod >> shift;
    big = |sh[127:63];
  end

  always_ff @(posedge clk) begin
    if (neg4) begin
      y <= big ? ljf_pkg::SMin : $signed(64'(-sh[63:0]));
    end else begin
      y <= big ? ljf_pkg::SMax : $signed(sh[63:0]);
    end
  end

endmodule

// ===== hw/rtl/ljf_delay.sv =====
// item record shift line matching the multiplier latency
// uses ljf_pkg record type and latency constant
module ljf_delay (
  input  logic               clk,
  input  logic               rst,
  input  ljf_pkg::ljf_rec_t  rec_in,
  output ljf_pkg::ljf_rec_t  rec_out
);

  ljf_pkg::ljf_rec_t line [ljf_pkg::SmulLat];

  always_ff @(posedge clk) begin
    line[0] <= ljf_pkg::gate_valid(rec_in, rst);
    for (int i = 1; i < ljf_pkg::SmulLat; i++) begin
      line[i] <= ljf_pkg::gate_valid(line[i-1], rst);
    end
  end

  assign rec_out = line[ljf_pkg::SmulLat-1];

endmodule

// ===== hw/rtl/ljf_sqrt.sv =====
// pipelined integer square root of the squared separation, one root bit per stage
// uses ljf_pkg record type; result lands in the r field
module ljf_sqrt (
  input  logic               clk,
  input  logic               rst,
  input  ljf_pkg::ljf_rec_t  rec_in,
  output ljf_pkg::ljf_rec_t  rec_out
);

  ljf_pkg::ljf_rec_t rec_s [ljf_pkg::SqrtSteps+1];
  logic [63:0]       n_s   [ljf_pkg::SqrtSteps+1];
  logic [63:0]       res_s [ljf_pkg::SqrtSteps+1];

  assign rec_s[0] = rec_in;
  assign n_s[0]   = rec_in.d2[63:0];
  assign res_s[0] = '0;

  for (genvar g = 0; g < ljf_pkg::SqrtSteps; g++) begin : g_step
    localparam logic [63:0] Bit = 64'd1 << (2 * (ljf_pkg::SqrtSteps - 1 - g));
    logic [63:0] trial;
    assign trial = res_s[g] + Bit;
    always_ff @(posedge clk) begin
      rec_s[g+1] <= ljf_pkg::gate_valid(rec_s[g], rst);
      if (n_s[g] >= trial) begin
        n_s[g+1]   <= n_s[g] - trial;
        res_s[g+1] <= (res_s[g] >> 1) + Bit;
      end else begin
        n_s[g+1]   <= n_s[g];
        res_s[g+1] <= res_s[g] >> 1;
      end
    end
  end

  always_comb begin
    rec_out   = rec_s[ljf_pkg::SqrtSteps];
    rec_out.r = res_s[ljf_pkg::SqrtSteps][31:0];
  end

endmodule

// ===== hw/rtl/ljf_div.sv =====
// pipelined restoring divider for the inverse distance 2^56 / r, one quotient bit per stage
// uses ljf_pkg record type; result lands in the q field
module ljf_div (
  input  logic               clk,
  input  logic               rst,
  input  ljf_pkg::ljf_rec_t  rec_in,
  output ljf_pkg::ljf_rec_t  rec_out
);

  ljf_pkg::ljf_rec_t rec_s [ljf_pkg::DivSteps+1];
  logic [32:0]       rmd_s [ljf_pkg::DivSteps+1];
  logic [ljf_pkg::DivSteps-1:0] quo_s [ljf_pkg::DivSteps+1];

  assign rec_s[0] = rec_in;
  assign rmd_s[0] = '0;
  assign quo_s[0] = '0;

  for (genvar g = 0; g < ljf_pkg::DivSteps; g++) begin : g_step
    localparam logic DBit = (g == 0);
    logic [32:0] shl;
    assign shl = {rmd_s[g][31:0], DBit};
    always_ff @(posedge clk) begin
      rec_s[g+1] <= ljf_pkg::gate_valid(rec_s[g], rst);
      if (shl >= {1'b0, rec_s[g].r}) begin
        rmd_s[g+1] <= shl - {1'b0, rec_s[g].r};
        quo_s[g+1] <= {quo_s[g][ljf_pkg::DivSteps-2:0], 1'b1};
      end else begin
        rmd_s[g+1] <= shl;
        quo_s[g+1] <= {quo_s[g][ljf_pkg::DivSteps-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    rec_out   = rec_s[ljf_pkg::DivSteps];
    rec_out.q = $signed(64'(quo_s[ljf_pkg::DivSteps]));
  end

endmodule

// ===== hw/rtl/shifted_lj_pair_force_kernel.sv =====
// top level of the shifted-cutoff 12-6 pair force kernel
// depends on ljf_pkg, ljf_smul, ljf_delay, ljf_sqrt, ljf_div
//
// usage:
//   an item (two points and a pair weight) is taken at each rising edge with
//   start high and busy low; busy is only high during reset, so one item can
//   enter every cycle.
//   each item gives one result, shown on result for one cycle with done high;
//   results leave in item order, one per cycle at most.
//   the pipeline holds 5 front stages (separation, magnitude, squares, sum, cutoff
//   test), 32 square root stages, 57 divider stages for the inverse distance, nine
//   rows of multipliers plus three add stages and one output register.
//   registers are written through cfg_valid/cfg_ready with cfg_index and
//   cfg_data; the user must write them only while no item is in flight, which
//   the block itself does not enforce; cfg_ready is high outside reset.
//   reset (rst, synchronous) empties the pipeline and loads the register
//   defaults; the receiver cannot stall, so done is never held back.
module shifted_lj_pair_force_kernel (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  ljf_pkg::ljf_in_t  operands,
  output logic              done,
  output ljf_pkg::ljf_out_t result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_data
);

  logic [30:0]        sigma, y_zero, cutoff_radius, inv_s0_sq;
  logic signed [31:0] strength, energy_shift, slope_shift;
  logic [45:0]        ys;
  logic [61:0]        rcsq;
  logic signed [34:0] a6;

  assign busy      = rst;
  assign cfg_ready = ~rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      sigma         <= ljf_pkg::SigmaReset;
      y_zero        <= ljf_pkg::YZeroReset;
      strength      <= ljf_pkg::StrengthReset;
      cutoff_radius <= ljf_pkg::CutoffReset;
      energy_shift  <= '0;
      slope_shift   <= '0;
      inv_s0_sq     <= ljf_pkg::InvS0SqReset;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        ljf_pkg::CfgSigma:    sigma         <= cfg_data[30:0];
        ljf_pkg::CfgYZero:    y_zero        <= cfg_data[30:0];
        ljf_pkg::CfgStrength: strength      <= $signed(cfg_data);
        ljf_pkg::CfgCutoff:   cutoff_radius <= cfg_data[30:0];
        ljf_pkg::CfgEShift:   energy_shift  <= $signed(cfg_data);
        ljf_pkg::CfgSShift:   slope_shift   <= $signed(cfg_data);
        ljf_pkg::CfgInvS0Sq:  inv_s0_sq     <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // derived constants, settled long before an item reaches them
  logic [61:0] ys_full;
  assign ys_full = {31'b0, y_zero} * {31'b0, sigma};

  always_ff @(posedge clk) begin
    ys   <= ys_full[61:16];
    rcsq <= {31'b0, cutoff_radius} * {31'b0, cutoff_radius};
    a6   <= 35'(strength) * 35'sd6;
  end

  logic signed [63:0] sl64, sl256, es256, a64, a6_64;
  assign sl64  = 64'(slope_shift);
  assign sl256 = 64'(slope_shift) <<< 8;
  assign es256 = 64'(energy_shift) <<< 8;
  assign a64   = 64'(strength);
  assign a6_64 = 64'(a6);

  // front stages
  ljf_pkg::ljf_rec_t rec0, f1, f2, f3, f4, f5;
  ljf_pkg::ljf_rec_t r2, r3, r4, r5;
  logic [63:0] ex, ey, ez;

  always_comb begin
    rec0       = '0;
    rec0.valid = start & ~busy;
    rec0.dx    = 33'(operands.xi) - 33'(operands.xj);
    rec0.dy    = 33'(operands.yi) - 33'(operands.yj);
    rec0.dz    = 33'(operands.zi) - 33'(operands.zj);
    rec0.pw    = operands.pair_weight;
  end

  always_comb begin
    r2    = f1;
    r2.mx = ljf_pkg::mag33(f1.dx);
    r2.my = ljf_pkg::mag33(f1.dy);
    r2.mz = ljf_pkg::mag33(f1.dz);
  end

  assign ex = {32'b0, f2.mx};
  assign ey = {32'b0, f2.my};
  assign ez = {32'b0, f2.mz};

  always_comb begin
    r3     = f2;
    r3.sx  = ex * ex;
    r3.sy  = ey * ey;
    r3.sz  = ez * ez;
    r3.w   = $signed({33'b0, f2.pw} * {33'b0, inv_s0_sq});
    r3.far = (f2.mx >= {1'b0, cutoff_radius}) || (f2.my >= {1'b0, cutoff_radius}) ||
             (f2.mz >= {1'b0, cutoff_radius});
  end

  always_comb begin
    r4    = f3;
    r4.d2 = 66'(f3.sx) + 66'(f3.sy) + 66'(f3.sz);
  end

  always_comb begin
    r5 = f4;
    priority if (f4.far || f4.d2 >= 66'(rcsq)) begin
      r5.status = ljf_pkg::StBeyond;
    end else if (f4.d2 == '0) begin
      r5.status = ljf_pkg::StCoincident;
    end else begin
      r5.status = ljf_pkg::StInteract;
    end
  end

  always_ff @(posedge clk) begin
    f1 <= ljf_pkg::gate_valid(rec0, rst);
    f2 <= ljf_pkg::gate_valid(r2, rst);
    f3 <= ljf_pkg::gate_valid(r3, rst);
    f4 <= ljf_pkg::gate_valid(r4, rst);
    f5 <= ljf_pkg::gate_valid(r5, rst);
  end

  ljf_pkg::ljf_rec_t sq_out, dv_out;

  ljf_sqrt u_sqrt (.clk(clk), .rst(rst), .rec_in(f5), .rec_out(sq_out));
  ljf_div  u_div  (.clk(clk), .rst(rst), .rec_in(sq_out), .rec_out(dv_out));

  // powers of p and q
  ljf_pkg::ljf_rec_t m1d, m1, m2d, m2, m3d, m3, m4d, m4, c1, c1_next;
  logic signed [63:0] p_y, q2_y, p2_y, q4_y, p4_y, q6_y, p6_y, q7_y;

  ljf_smul u_p  (.clk(clk), .a($signed(64'(ys))), .b(dv_out.q), .shift(ljf_pkg::ShQ),
                 .y(p_y));
  ljf_smul u_q2 (.clk(clk), .a(dv_out.q), .b(dv_out.q), .shift(ljf_pkg::ShQ), .y(q2_y));
  ljf_delay u_d1 (.clk(clk), .rst(rst), .rec_in(dv_out), .rec_out(m1d));

  always_comb begin
    m1    = m1d;
    m1.p  = p_y;
    m1.q2 = q2_y;
  end

  ljf_smul u_p2 (.clk(clk), .a(m1.p), .b(m1.p), .shift(ljf_pkg::ShQ), .y(p2_y));
  ljf_smul u_q4 (.clk(clk), .a(m1.q2), .b(m1.q2), .shift(ljf_pkg::ShQ), .y(q4_y));
  ljf_delay u_d2 (.clk(clk), .rst(rst), .rec_in(m1), .rec_out(m2d));

  always_comb begin
    m2    = m2d;
    m2.p2 = p2_y;
    m2.q4 = q4_y;
  end

  ljf_smul u_p4 (.clk(clk), .a(m2.p2), .b(m2.p2), .shift(ljf_pkg::ShQ), .y(p4_y));
  ljf_smul u_q6 (.clk(clk), .a(m2.q4), .b(m2.q2), .shift(ljf_pkg::ShQ), .y(q6_y));
  ljf_delay u_d3 (.clk(clk), .rst(rst), .rec_in(m2), .rec_out(m3d));

  always_comb begin
    m3    = m3d;
    m3.p4 = p4_y;
    m3.q6 = q6_y;
  end

  ljf_smul u_p6 (.clk(clk), .a(m3.p4), .b(m3.p2), .shift(ljf_pkg::ShQ), .y(p6_y));
  ljf_smul u_q7 (.clk(clk), .a(m3.q6), .b(m3.q), .shift(ljf_pkg::ShQ), .y(q7_y));
  ljf_delay u_d4 (.clk(clk), .rst(rst), .rec_in(m3), .rec_out(m4d));

  always_comb begin
    m4    = m4d;
    m4.p6 = p6_y;
    m4.q7 = q7_y;
  end

  // bracket terms and distance past the cutoff
  always_comb begin
    c1_next     = m4;
    c1_next.ce  = (m4.p6 >>> 1) - ljf_pkg::One32;
    c1_next.cd  = ljf_pkg::One32 - m4.p6;
    c1_next.rmr = $signed({32'b0, m4.r}) - $signed({33'b0, cutoff_radius});
  end

  always_ff @(posedge clk) begin
    c1 <= ljf_pkg::gate_valid(c1_next, rst);
  end

  // energy and derivative
  ljf_pkg::ljf_rec_t m5d, m5, m6d, m6, s1, s2, s1_next, s2_next;
  logic signed [63:0] t1_y, t2_y, st_y, e_y, dv_y;

  ljf_smul u_t1 (.clk(clk), .a(c1.q6), .b(c1.ce), .shift(ljf_pkg::ShQ), .y(t1_y));
  ljf_smul u_t2 (.clk(clk), .a(c1.q7), .b(c1.cd), .shift(ljf_pkg::ShQ), .y(t2_y));
  ljf_smul u_st (.clk(clk), .a(sl64), .b(c1.rmr), .shift(ljf_pkg::ShS), .y(st_y));
  ljf_delay u_d5 (.clk(clk), .rst(rst), .rec_in(c1), .rec_out(m5d));

  always_comb begin
    m5    = m5d;
    m5.t1 = t1_y;
    m5.t2 = t2_y;
    m5.st = st_y;
  end

  ljf_smul u_e  (.clk(clk), .a(m5.t1), .b(a64), .shift(ljf_pkg::ShA), .y(e_y));
  ljf_smul u_dv (.clk(clk), .a(m5.t2), .b(a6_64), .shift(ljf_pkg::ShA), .y(dv_y));
  ljf_delay u_d6 (.clk(clk), .rst(rst), .rec_in(m5), .rec_out(m6d));

  always_comb begin
    m6    = m6d;
    m6.e  = e_y;
    m6.dv = dv_y;
  end

  always_comb begin
    s1_next    = m6;
    s1_next.e  = ljf_pkg::ssub(m6.e, m6.st);
    s1_next.dv = ljf_pkg::ssub(m6.dv, sl256);
    s2_next    = s1;
    s2_next.e  = ljf_pkg::ssub(s1.e, es256);
  end

  always_ff @(posedge clk) begin
    s1 <= ljf_pkg::gate_valid(s1_next, rst);
    s2 <= ljf_pkg::gate_valid(s2_next, rst);
  end

  // weighting and force scaling
  ljf_pkg::ljf_rec_t m7d, m7, m8d, m8, m9d, m9;
  logic signed [63:0] en_y, f_y, g_y, fx_y, fy_y, fz_y;

  ljf_smul u_en (.clk(clk), .a(s2.e), .b(s2.w), .shift(ljf_pkg::ShE), .y(en_y));
  ljf_smul u_f  (.clk(clk), .a(s2.dv), .b(s2.q), .shift(ljf_pkg::ShQ), .y(f_y));
  ljf_delay u_d7 (.clk(clk), .rst(rst), .rec_in(s2), .rec_out(m7d));

  always_comb begin
    m7    = m7d;
    m7.en = en_y;
    m7.f  = f_y;
  end

  ljf_smul u_g (.clk(clk), .a(m7.f), .b(m7.w), .shift(ljf_pkg::ShW), .y(g_y));
  ljf_delay u_d8 (.clk(clk), .rst(rst), .rec_in(m7), .rec_out(m8d));

  always_comb begin
    m8   = m8d;
    m8.g = g_y;
  end

  ljf_smul u_fx (.clk(clk), .a(64'(m8.dx)), .b(m8.g), .shift(ljf_pkg::ShS), .y(fx_y));
  ljf_smul u_fy (.clk(clk), .a(64'(m8.dy)), .b(m8.g), .shift(ljf_pkg::ShS), .y(fy_y));
  ljf_smul u_fz (.clk(clk), .a(64'(m8.dz)), .b(m8.g), .shift(ljf_pkg::ShS), .y(fz_y));
  ljf_delay u_d9 (.clk(clk), .rst(rst), .rec_in(m8), .rec_out(m9d));

  always_comb begin
    m9    = m9d;
    m9.fx = fx_y;
    m9.fy = fy_y;
    m9.fz = fz_y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= m9.valid;
    end
    result.status <= m9.status;
    if (m9.status == ljf_pkg::StInteract) begin
      result.pair_energy <= m9.en;
      result.force_x     <= m9.fx;
      result.force_y     <= m9.fy;
      result.force_z     <= m9.fz;
    end else begin
      result.pair_energy <= '0;
      result.force_x     <= '0;
      result.force_y     <= '0;
      result.force_z     <= '0;
    end
  end

endmodule

// ===== hw/rtl/ljf_checker.sv =====
// port level checks for the shifted 12-6 pair force kernel, bound to the top level
// uses ljf_pkg status codes and types
module ljf_checker (
  input logic              clk,
  input logic              rst,
  input logic              busy,
  input logic              done,
  input ljf_pkg::ljf_out_t result,
  input logic              cfg_ready
);

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.status == ljf_pkg::StInteract || result.status == ljf_pkg::StBeyond ||
              result.status == ljf_pkg::StCoincident))
    else $error("bad status code");

  a_zero_when_not_interacting: assert property (@(posedge clk) disable iff (rst)
    (done && result.status != ljf_pkg::StInteract) |->
      (result.pair_energy == '0 && result.force_x == '0 && result.force_y == '0 &&
       result.force_z == '0))
    else $error("nonzero result without interaction");

  a_no_done_after_reset: assert property (@(posedge clk)
    rst |=> !done)
    else $error("item after reset");

  a_busy_only_in_reset: assert property (@(posedge clk) disable iff (rst)
    !busy && cfg_ready)
    else $error("kernel refuses items outside reset");

endmodule

bind shifted_lj_pair_force_kernel ljf_checker u_ljf_checker (.*);
